@@ design/slfp_pkg.sv @@
// Shared types, constants and helpers for the static linked list free pool.
// Used by slfp_front, slfp_back and static_linked_list_free_pool_top.
`timescale 1ns / 1ps

package slfp_pkg;

   // Node array geometry; slots 0 and 1 hold no node, an index below FIRST_NODE ends a chain
   localparam int NODE_SLOTS = 64;
   localparam int SLOT_W     = 6;
   localparam int FIRST_NODE = 2;
   // Walk count at which the final node of a full list is emitted
   localparam int WALK_LAST  = NODE_SLOTS - 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Input action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_SHOW   = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] value;
   } slfp_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        data_out;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } slfp_rsp_type;

   // Classified command held in the queue
   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_DELETE,
      CMD_SHOW
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] value;
   } cmd_entry_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } cmd_port_type;

   // Map any slot index outside the node array to end of chain
   function automatic logic [SLOT_W-1:0] fix_index(input logic [SLOT_W-1:0] i);
      logic [SLOT_W:0] wide;
      wide = {1'b0, i};
      return (wide < (SLOT_W+1)'(NODE_SLOTS)) ? i : '0;
   endfunction

   // Link value of a slot that was never written since reset
   function automatic logic [SLOT_W-1:0] link_reset(input logic [SLOT_W-1:0] i);
      logic [SLOT_W:0] nxt;
      nxt = {1'b0, i} + (SLOT_W+1)'(1);
      if (i < SLOT_W'(FIRST_NODE)) begin
         return '0;
      end
      return (nxt < (SLOT_W+1)'(NODE_SLOTS)) ? nxt[SLOT_W-1:0] : '0;
   endfunction

endpackage

@@ design/slfp_front.sv @@
// Front end: accepts request transfers, classifies the action and queues commands.
// Depends on slfp_pkg.
`timescale 1ns / 1ps

module slfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  slfp_pkg::slfp_req_type req_data,
   output slfp_pkg::cmd_port_type cmd_port,
   input  logic                  cmd_pop
);

   slfp_pkg::cmd_entry_type queue_ff [slfp_pkg::QUEUE_DEPTH];
   logic [slfp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [slfp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [slfp_pkg::QPTR_W:0]   count_ff, count_in;
   logic                        known;
   logic                        push;
   logic                        pop;
   slfp_pkg::cmd_entry_type     entry;

   // Classify the action; the unused code is taken and dropped
   always_comb begin
      known       = 1'b1;
      entry.value = req_data.value;
      entry.cmd   = slfp_pkg::CMD_INSERT;
      unique case (req_data.action)
         slfp_pkg::ACT_INSERT: entry.cmd = slfp_pkg::CMD_INSERT;
         slfp_pkg::ACT_DELETE: entry.cmd = slfp_pkg::CMD_DELETE;
         slfp_pkg::ACT_SHOW:   entry.cmd = slfp_pkg::CMD_SHOW;
         default:              known     = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != (slfp_pkg::QPTR_W+1)'(slfp_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready && known;
   assign pop       = cmd_pop && (count_ff != '0);

   assign cmd_port.valid = (count_ff != '0);
   assign cmd_port.entry = queue_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == slfp_pkg::QPTR_W'(slfp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + slfp_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == slfp_pkg::QPTR_W'(slfp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + slfp_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (slfp_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (slfp_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the queued command
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

@@ design/slfp_back.sv @@
// Back end: runs insert, delete and walk on the link and data memories.
// Depends on slfp_pkg; holds the result register.
`timescale 1ns / 1ps

module slfp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  slfp_pkg::cmd_port_type cmd_port,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output slfp_pkg::slfp_rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INS_WR,
      ST_DEL_WR,
      ST_WALK
   } state_type;

   localparam int SW = slfp_pkg::SLOT_W;

   // Memories and valid bits of the link store
   logic [SW-1:0] link_mem [slfp_pkg::NODE_SLOTS];
   logic [7:0]    data_mem [slfp_pkg::NODE_SLOTS];
   logic [slfp_pkg::NODE_SLOTS-1:0] link_vld_ff;
   logic [SW-1:0] link_rd_ff;
   logic          link_vld_rd_ff;
   logic [7:0]    data_rd_ff;

   // Control and payload registers
   state_type              state_ff, state_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [7:0]             val_ff, val_in;
   logic [SW-1:0]          cnt_ff, cnt_in;
   logic [SW-1:0]          list_head_ff, list_head_in;
   logic [SW-1:0]          pool_head_ff, pool_head_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   slfp_pkg::slfp_rsp_type rsp_data_ff, rsp_data_in;

   // Memory port controls
   logic          rd_en;
   logic [SW-1:0] rd_addr;
   logic          link_we;
   logic          data_we;
   logic [SW-1:0] wr_addr;
   logic [SW-1:0] wr_link;
   logic [7:0]    wr_data;

   logic          out_free;
   logic          emit;
   logic [SW-1:0] link_eff;
   logic [SW-1:0] nxt;
   logic [SW-1:0] head;
   logic          done;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign link_eff = link_vld_rd_ff ? link_rd_ff : slfp_pkg::link_reset(slot_ff);
   assign nxt      = slfp_pkg::fix_index(link_eff);
   assign done     = (nxt < SW'(slfp_pkg::FIRST_NODE)) ||
                     (cnt_ff == SW'(slfp_pkg::WALK_LAST));

   // Sequence each command and form the next result
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      list_head_in = list_head_ff;
      pool_head_in = pool_head_ff;
      rsp_data_in  = rsp_data_ff;
      emit         = 1'b0;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = slot_ff;
      link_we      = 1'b0;
      data_we      = 1'b0;
      wr_addr      = slot_ff;
      wr_link      = '0;
      wr_data      = val_ff;
      head         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_port.valid && out_free) begin
               cmd_pop = 1'b1;
               head = (cmd_port.entry.cmd == slfp_pkg::CMD_INSERT) ?
                      slfp_pkg::fix_index(pool_head_ff) :
                      slfp_pkg::fix_index(list_head_ff);
               if (head < SW'(slfp_pkg::FIRST_NODE)) begin
                  // Pool full or list empty: answer at once
                  emit = 1'b1;
                  rsp_data_in.status = (cmd_port.entry.cmd == slfp_pkg::CMD_INSERT) ?
                                       slfp_pkg::STATUS_FULL : slfp_pkg::STATUS_EMPTY;
                  rsp_data_in.data_out = '0;
                  rsp_data_in.slot     = '0;
                  rsp_data_in.last     = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = head;
                  slot_in = head;
                  val_in  = cmd_port.entry.value;
                  cnt_in  = '0;
                  unique case (cmd_port.entry.cmd)
                     slfp_pkg::CMD_INSERT: state_in = ST_INS_WR;
                     slfp_pkg::CMD_DELETE: state_in = ST_DEL_WR;
                     slfp_pkg::CMD_SHOW:   state_in = ST_WALK;
                     default:              state_in = ST_IDLE;
                  endcase
               end
            end
         end
         ST_INS_WR: begin
            if (out_free) begin
               // Pop the free slot, store the byte, link it at the list head
               pool_head_in = nxt;
               data_we      = 1'b1;
               link_we      = 1'b1;
               wr_link      = slfp_pkg::fix_index(list_head_ff);
               list_head_in = slot_ff;
               emit         = 1'b1;
               rsp_data_in.status   = slfp_pkg::STATUS_OK;
               rsp_data_in.data_out = val_ff;
               rsp_data_in.slot     = slot_ff;
               rsp_data_in.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DEL_WR: begin
            if (out_free) begin
               // Unlink the head node and push its slot on the pool
               list_head_in = nxt;
               link_we      = 1'b1;
               wr_link      = slfp_pkg::fix_index(pool_head_ff);
               pool_head_in = slot_ff;
               emit         = 1'b1;
               rsp_data_in.status   = slfp_pkg::STATUS_OK;
               rsp_data_in.data_out = data_rd_ff;
               rsp_data_in.slot     = slot_ff;
               rsp_data_in.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               // Emit this node and fetch the next one
               emit = 1'b1;
               rsp_data_in.status   = slfp_pkg::STATUS_OK;
               rsp_data_in.data_out = data_rd_ff;
               rsp_data_in.slot     = slot_ff;
               rsp_data_in.last     = done;
               if (done) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = nxt;
                  slot_in = nxt;
                  cnt_in  = cnt_ff + SW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         list_head_ff <= '0;
         pool_head_ff <= SW'(slfp_pkg::FIRST_NODE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         pool_head_ff <= pool_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff     <= slot_in;
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Mark link entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (link_we) begin
         link_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Link and data memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (data_we) begin
         data_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         link_rd_ff     <= link_mem[rd_addr];
         link_vld_rd_ff <= link_vld_ff[rd_addr];
         data_rd_ff     <= data_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/static_linked_list_free_pool_top.sv @@
// Top level of the static linked list free pool: front end, command queue, back end.
// Depends on slfp_pkg, slfp_front and slfp_back.
//
//   port group   dir   payload          meaning
//   req_*        in    slfp_req_type    action and byte, valid/ready
//   rsp_*        out   slfp_rsp_type    status, byte, slot, last flag, valid/ready
//
// Insert and delete read the link and data memories at the head slot when idle,
// then write back and load the result in ST_INS_WR or ST_DEL_WR. Show reads the head
// slot, then emits each node while it fetches the next one; full pool and empty list
// answer from the idle state. The link memory has a single read port.
// Reset is synchronous and needs no clearing pass: link entries carry valid bits.
// The front queue holds two commands, so requests transfer while the back end
// waits on a stalled result register.
`timescale 1ns / 1ps

module static_linked_list_free_pool_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  slfp_pkg::slfp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output slfp_pkg::slfp_rsp_type rsp_data
);

   slfp_pkg::cmd_port_type cmd_port;
   logic                   cmd_pop;

   slfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_port  (cmd_port),
      .cmd_pop   (cmd_pop)
   );

   slfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_port  (cmd_port),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
